### rtl/mlfq_pkg.sv
// Shared widths, limits and register indexes of the three-level feedback queue scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;

    localparam int MaxTasks  = 16;
    localparam int SlotW     = 4;
    localparam int TimeW     = 16;
    localparam int NowW      = 21;
    localparam int CountW    = 5;
    localparam int QuantW    = 8;
    localparam int NumLevels = 3;
    localparam int LevelW    = 2;

    localparam logic [NowW-1:0]  NowMax = {NowW{1'b1}};
    localparam logic [TimeW-1:0] SwMax  = {TimeW{1'b1}};

    // Stream payload widths, padded to whole bytes.
    localparam int SDataW = 40;
    localparam int MDataW = 64;

    // Operation carried in s_tuser.
    localparam logic OpLoad = 1'b0;
    localparam logic OpStep = 1'b1;

    // Configuration port.
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 8;
    localparam logic [CfgIdxW-1:0] RegQuantum0 = 2'd0;
    localparam logic [CfgIdxW-1:0] RegQuantum1 = 2'd1;

    localparam logic [QuantW-1:0] Quantum0Reset = 8'd5;
    localparam logic [QuantW-1:0] Quantum1Reset = 8'd10;

endpackage

### rtl/mlfq_three_level_scheduler_unit.sv
// Three-level feedback queue scheduler: task table, three queues and the step sequencer.
`timescale 1ns / 1ps
// A load transaction (s_tuser = 0) writes one task's arrival time and burst into the
// task table, unless the burst is zero, and returns one result. A step transaction
// (s_tuser = 1) first walks the sixteen table slots, one slot per cycle, admitting each
// arrived, unfinished and unqueued task to the tail of the top queue; it then picks the
// head of the highest non-empty queue in ST_PICK and retires the slice in ST_FINISH, or
// returns an idle tick from ST_PICK if all queues are empty. A single comparator serves
// both the arrival test of the walk and the quantum limit of the dispatch. The input is
// taken only while the sequencer is idle, but a result may wait in the output register
// meanwhile; a stalled output holds the sequencer in its last state. Quanta are to be
// written through the cfg port only while no transaction is in progress; the block does
// not enforce this. A quantum of zero behaves as one.
module mlfq_three_level_scheduler_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata, from bit 0: task_slot[3:0], arrival[15:0], burst[15:0], zero padding.
    input  logic [mlfq_pkg::SDataW-1:0]    s_tdata,
    // s_tuser: op (0 load, 1 step).
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata, from bit 0: task_run[3:0], level[1:0], slice_start[20:0],
    // run_length[15:0], finished, all_done, switches[15:0], zero padding.
    output logic [mlfq_pkg::MDataW-1:0]    m_tdata,
    // m_tuser: idle.
    output logic [0:0]                     m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mlfq_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [mlfq_pkg::CfgDataW-1:0]  cfg_data
);
    import mlfq_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_PICK   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [QuantW-1:0] quantum0_reg, quantum1_reg;

    // Captured input transaction.
    logic [SlotW-1:0]  slot_reg, slot_next;
    logic [TimeW-1:0]  arr_in_reg, arr_in_next;
    logic [TimeW-1:0]  burst_reg, burst_next;

    // Task table.
    logic [TimeW-1:0]  arrival_reg   [MaxTasks];
    logic [TimeW-1:0]  remaining_reg [MaxTasks];
    logic [MaxTasks-1:0] queued_reg, queued_next;
    logic [MaxTasks-1:0] loaded_reg, loaded_next;

    // Queues.
    logic [SlotW-1:0]  fifo_reg [NumLevels][MaxTasks];
    logic [SlotW-1:0]  head_reg [NumLevels];
    logic [CountW-1:0] cnt_reg  [NumLevels];

    logic [NowW-1:0]   now_reg, now_next;
    logic              prev_valid_reg, prev_valid_next;
    logic [SlotW-1:0]  prev_task_reg, prev_task_next;
    logic [TimeW-1:0]  sw_reg, sw_next;
    logic [CountW-1:0] loaded_cnt_reg, loaded_cnt_next;
    logic [CountW-1:0] done_cnt_reg, done_cnt_next;

    // Sequencer working registers.
    logic [SlotW-1:0]  idx_reg, idx_next;
    logic [SlotW-1:0]  task_reg, task_next;
    logic [LevelW-1:0] lvl_reg, lvl_next;
    logic [TimeW-1:0]  run_reg, run_next;
    logic [TimeW-1:0]  left_reg, left_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic              o_idle_reg, o_idle_next;
    logic [SlotW-1:0]  o_task_reg, o_task_next;
    logic [LevelW-1:0] o_lvl_reg, o_lvl_next;
    logic [NowW-1:0]   o_start_reg, o_start_next;
    logic [TimeW-1:0]  o_run_reg, o_run_next;
    logic              o_fin_reg, o_fin_next;
    logic              o_done_reg, o_done_next;
    logic [TimeW-1:0]  o_sw_reg, o_sw_next;

    // Table and queue write controls.
    logic              rem_we;
    logic [SlotW-1:0]  rem_wa;
    logic [TimeW-1:0]  rem_wd;
    logic              arr_we;
    logic              push_en;
    logic [LevelW-1:0] push_lvl;
    logic [SlotW-1:0]  push_val;
    logic              pop_en;

    logic              out_free;
    logic [SlotW-1:0]  rd_idx;
    logic [TimeW-1:0]  rem_rd;
    logic [TimeW-1:0]  arr_rd;
    logic              lvl_none;
    logic [LevelW-1:0] lvl_pick;
    logic [SlotW-1:0]  head_task;
    logic [QuantW-1:0] q0_eff, q1_eff;
    logic [TimeW-1:0]  quantum;
    logic [NowW-1:0]   cmp_a, cmp_b;
    logic              cmp_lt;
    logic [TimeW-1:0]  run_c;
    logic [NowW:0]     now_sum;
    logic [SlotW-1:0]  push_tail;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_idle_reg;
    assign m_tdata  = {3'b000, o_sw_reg, o_done_reg, o_fin_reg, o_run_reg, o_start_reg,
                       o_lvl_reg, o_task_reg};

    // One read port of the remaining-time table, shared by the walk, the load and the dispatch.
    always_comb begin
        unique case (state_reg)
            ST_SCAN: rd_idx = idx_reg;
            ST_LOAD: rd_idx = slot_reg;
            default: rd_idx = head_task;
        endcase
    end
    assign rem_rd = remaining_reg[rd_idx];
    assign arr_rd = arrival_reg[idx_reg];

    assign lvl_none = (cnt_reg[0] == '0) && (cnt_reg[1] == '0) && (cnt_reg[2] == '0);
    always_comb begin
        priority if (cnt_reg[0] != '0) begin
            lvl_pick = 2'd0;
        end else if (cnt_reg[1] != '0) begin
            lvl_pick = 2'd1;
        end else begin
            lvl_pick = 2'd2;
        end
    end
    assign head_task = fifo_reg[lvl_pick][head_reg[lvl_pick]];

    assign q0_eff = (quantum0_reg == '0) ? 8'd1 : quantum0_reg;
    assign q1_eff = (quantum1_reg == '0) ? 8'd1 : quantum1_reg;
    always_comb begin
        unique case (lvl_pick)
            2'd0:    quantum = {8'b0, q0_eff};
            2'd1:    quantum = {8'b0, q1_eff};
            default: quantum = rem_rd;
        endcase
    end

    // The shared comparator: arrival test during the walk, quantum limit at dispatch.
    always_comb begin
        if (state_reg == ST_SCAN) begin
            cmp_a = now_reg;
            cmp_b = {5'b0, arr_rd};
        end else begin
            cmp_a = {5'b0, rem_rd};
            cmp_b = {5'b0, quantum};
        end
    end
    assign cmp_lt = (cmp_a < cmp_b);
    assign run_c  = cmp_lt ? rem_rd : quantum;

    assign now_sum   = {1'b0, now_reg} + {6'b0, run_reg};
    assign push_tail = head_reg[push_lvl] + cnt_reg[push_lvl][SlotW-1:0];

    always_comb begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        arr_in_next     = arr_in_reg;
        burst_next      = burst_reg;
        queued_next     = queued_reg;
        loaded_next     = loaded_reg;
        now_next        = now_reg;
        prev_valid_next = prev_valid_reg;
        prev_task_next  = prev_task_reg;
        sw_next         = sw_reg;
        loaded_cnt_next = loaded_cnt_reg;
        done_cnt_next   = done_cnt_reg;
        idx_next        = idx_reg;
        task_next       = task_reg;
        lvl_next        = lvl_reg;
        run_next        = run_reg;
        left_next       = left_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        o_idle_next     = o_idle_reg;
        o_task_next     = o_task_reg;
        o_lvl_next      = o_lvl_reg;
        o_start_next    = o_start_reg;
        o_run_next      = o_run_reg;
        o_fin_next      = o_fin_reg;
        o_done_next     = o_done_reg;
        o_sw_next       = o_sw_reg;
        rem_we          = 1'b0;
        rem_wa          = slot_reg;
        rem_wd          = burst_reg;
        arr_we          = 1'b0;
        push_en         = 1'b0;
        push_lvl        = 2'd0;
        push_val        = idx_reg;
        pop_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    slot_next   = s_tdata[3:0];
                    arr_in_next = s_tdata[19:4];
                    burst_next  = s_tdata[35:20];
                    idx_next    = '0;
                    state_next  = (s_tuser[0] == OpStep) ? ST_SCAN : ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    if (burst_reg != '0) begin
                        if (!loaded_reg[slot_reg]) begin
                            loaded_next[slot_reg] = 1'b1;
                            loaded_cnt_next       = loaded_cnt_reg + 5'd1;
                        end else if (rem_rd == '0 && done_cnt_reg != '0) begin
                            // A finished task comes back to life.
                            done_cnt_next = done_cnt_reg - 5'd1;
                        end
                        arr_we = 1'b1;
                        rem_we = 1'b1;
                    end
                    m_valid_next = 1'b1;
                    o_idle_next  = 1'b0;
                    o_task_next  = '0;
                    o_lvl_next   = '0;
                    o_start_next = '0;
                    o_run_next   = '0;
                    o_fin_next   = 1'b0;
                    o_done_next  = (done_cnt_next == loaded_cnt_next);
                    o_sw_next    = sw_reg;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (rem_rd != '0 && !queued_reg[idx_reg] && !cmp_lt) begin
                    queued_next[idx_reg] = 1'b1;
                    push_en              = 1'b1;
                end
                idx_next = idx_reg + 4'd1;
                if (idx_reg == SlotW'(MaxTasks - 1)) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                if (lvl_none) begin
                    if (out_free) begin
                        m_valid_next    = 1'b1;
                        o_idle_next     = 1'b1;
                        o_task_next     = '0;
                        o_lvl_next      = '0;
                        o_start_next    = now_reg;
                        o_run_next      = '0;
                        o_fin_next      = 1'b0;
                        o_done_next     = (done_cnt_reg == loaded_cnt_reg);
                        o_sw_next       = sw_reg;
                        now_next        = (now_reg == NowMax) ? now_reg : now_reg + 21'd1;
                        prev_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    pop_en    = 1'b1;
                    task_next = head_task;
                    lvl_next  = lvl_pick;
                    run_next  = run_c;
                    left_next = rem_rd - run_c;
                    if (prev_valid_reg && prev_task_reg != head_task && sw_reg != SwMax) begin
                        sw_next = sw_reg + 16'd1;
                    end
                    prev_valid_next = 1'b1;
                    prev_task_next  = head_task;
                    state_next      = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    rem_we   = 1'b1;
                    rem_wa   = task_reg;
                    rem_wd   = left_reg;
                    now_next = now_sum[NowW] ? NowMax : now_sum[NowW-1:0];
                    if (left_reg == '0) begin
                        queued_next[task_reg] = 1'b0;
                        done_cnt_next         = done_cnt_reg + 5'd1;
                    end else begin
                        // Only the two upper levels can leave work behind.
                        push_en  = 1'b1;
                        push_lvl = (lvl_reg == 2'd0) ? 2'd1 : 2'd2;
                        push_val = task_reg;
                    end
                    m_valid_next = 1'b1;
                    o_idle_next  = 1'b0;
                    o_task_next  = task_reg;
                    o_lvl_next   = lvl_reg;
                    o_start_next = now_reg;
                    o_run_next   = run_reg;
                    o_fin_next   = (left_reg == '0);
                    o_done_next  = (done_cnt_next == loaded_cnt_reg);
                    o_sw_next    = sw_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            quantum0_reg   <= Quantum0Reset;
            quantum1_reg   <= Quantum1Reset;
            queued_reg     <= '0;
            loaded_reg     <= '0;
            now_reg        <= '0;
            prev_valid_reg <= 1'b0;
            prev_task_reg  <= '0;
            sw_reg         <= '0;
            loaded_cnt_reg <= '0;
            done_cnt_reg   <= '0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
            for (int l = 0; l < NumLevels; l++) begin
                head_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
            for (int t = 0; t < MaxTasks; t++) begin
                remaining_reg[t] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            queued_reg     <= queued_next;
            loaded_reg     <= loaded_next;
            now_reg        <= now_next;
            prev_valid_reg <= prev_valid_next;
            prev_task_reg  <= prev_task_next;
            sw_reg         <= sw_next;
            loaded_cnt_reg <= loaded_cnt_next;
            done_cnt_reg   <= done_cnt_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_index == RegQuantum0) begin
                quantum0_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == RegQuantum1) begin
                quantum1_reg <= cfg_data;
            end
            if (rem_we) begin
                remaining_reg[rem_wa] <= rem_wd;
            end
            if (push_en) begin
                cnt_reg[push_lvl] <= cnt_reg[push_lvl] + 5'd1;
            end
            if (pop_en) begin
                head_reg[lvl_pick] <= head_reg[lvl_pick] + 4'd1;
                cnt_reg[lvl_pick]  <= cnt_reg[lvl_pick] - 5'd1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        slot_reg    <= slot_next;
        arr_in_reg  <= arr_in_next;
        burst_reg   <= burst_next;
        task_reg    <= task_next;
        lvl_reg     <= lvl_next;
        run_reg     <= run_next;
        left_reg    <= left_next;
        o_idle_reg  <= o_idle_next;
        o_task_reg  <= o_task_next;
        o_lvl_reg   <= o_lvl_next;
        o_start_reg <= o_start_next;
        o_run_reg   <= o_run_next;
        o_fin_reg   <= o_fin_next;
        o_done_reg  <= o_done_next;
        o_sw_reg    <= o_sw_next;
        if (arr_we) begin
            arrival_reg[slot_reg] <= arr_in_reg;
        end
        if (push_en) begin
            fifo_reg[push_lvl][push_tail] <= push_val;
        end
    end

endmodule

### rtl/mlfq_checker.sv
// Port-level checks on the scheduler and their attachment to the top level.
`timescale 1ns / 1ps
module mlfq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mlfq_pkg::MDataW-1:0]    m_tdata,
    input logic [0:0]                     m_tuser
);
    import mlfq_pkg::*;

    // A result that is not taken stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    // Every transaction keeps the sequencer busy for at least the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while a transaction is in progress");

    // An idle tick names no task, level or run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[3:0] == 4'd0 && m_tdata[5:4] == 2'd0 &&
            m_tdata[42:27] == 16'd0 && !m_tdata[43])
        else $error("idle tick carries dispatch fields");

    // Only three queue levels exist.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[5:4] != 2'd3)
        else $error("result names a fourth queue level");

    // A task can only finish after running for at least one time unit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[43] |-> m_tdata[42:27] != 16'd0)
        else $error("task finished with an empty slice");

endmodule

bind mlfq_three_level_scheduler_unit mlfq_checker u_mlfq_checker (.*);
